>>> rtl/core/lstp_pkg.sv
// ----------------------------------------------------------------------------
// lstp_pkg
// Types, codes and character tables shared by the scan telegram parser.
// ----------------------------------------------------------------------------
package lstp_pkg;

  localparam int unsigned ValueWidthDef = 16;

  localparam int unsigned ResFifoDepth = 8;
  localparam int unsigned ResPtrW      = $clog2(ResFifoDepth);
  localparam int unsigned ResCntW      = $clog2(ResFifoDepth + 1);

  localparam logic [15:0] MaxRangeReset = 16'd10000;

  localparam logic [7:0] ByteStx = 8'h02;
  localparam logic [7:0] ByteEtx = 8'h03;
  localparam logic [7:0] ByteSep = 8'h20;

  // token numbers with a fixed meaning
  localparam logic [4:0] TokCommand = 5'd1;
  localparam logic [4:0] TokName    = 5'd2;
  localparam logic [4:0] TokChannel = 5'd21;
  localparam logic [4:0] TokCount   = 5'd26;
  localparam logic [4:0] TokMax     = 5'd31;

  localparam logic [3:0] CommandMinLen = 4'd3;
  localparam logic [3:0] NameLen       = 4'd11;
  localparam logic [3:0] ChannelLen    = 4'd5;
  localparam logic [3:0] CharPosMax    = 4'd15;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_TYPE   = 3'd1,
    ST_BAD_NAME   = 3'd2,
    ST_NOT_DIST   = 3'd3,
    ST_SHORT_SCAN = 3'd4
  } status_e;

  typedef enum logic {
    KIND_POINT  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [15:0] max_range_mm;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] point_index;
    logic [15:0] distance_mm;
    logic        in_range;
    status_e     status;
    logic [15:0] point_total;
    logic        last;
  } res_t;

  // up to two results per parsed byte
  typedef struct packed {
    logic [1:0] num;
    res_t       res0;
    res_t       res1;
  } push_t;

  // bit 4 set when the byte is a hex digit, low nibble its value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") r = {1'b1, 4'(c - "0")};
    else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - "a" + 8'd10)};
    else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - "A" + 8'd10)};
    return r;
  endfunction

  function automatic logic [7:0] name_char(input logic [3:0] pos);
    logic [7:0] r;
    case (pos)
      4'd0:    r = "L";
      4'd1:    r = "M";
      4'd2:    r = "D";
      4'd3:    r = "s";
      4'd4:    r = "c";
      4'd5:    r = "a";
      4'd6:    r = "n";
      4'd7:    r = "d";
      4'd8:    r = "a";
      4'd9:    r = "t";
      4'd10:   r = "a";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] channel_char(input logic [3:0] pos);
    logic [7:0] r;
    case (pos)
      4'd0:    r = "D";
      4'd1:    r = "I";
      4'd2:    r = "S";
      4'd3:    r = "T";
      4'd4:    r = "1";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/lstp_stream_if.sv
// ----------------------------------------------------------------------------
// lstp_stream_if
// Valid/ready channel carrying one request payload of type T.
// ----------------------------------------------------------------------------
interface lstp_stream_if #(
  parameter type T = logic [7:0]
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/lstp_parser.sv
// ----------------------------------------------------------------------------
// lstp_parser
// Input byte register and the single-pass token parser producing results.
// ----------------------------------------------------------------------------
module lstp_parser #(
  parameter int unsigned VALUE_WIDTH = lstp_pkg::ValueWidthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            byte_valid_i,
  input  logic [7:0]      byte_i,
  input  logic [15:0]     max_range_i,
  output logic            busy_o,
  output lstp_pkg::push_t push_o
);
  import lstp_pkg::*;

  localparam int unsigned AccW = VALUE_WIDTH + 1;
  localparam int unsigned SumW = VALUE_WIDTH + 5;
  localparam int unsigned CmpW = (VALUE_WIDTH > 16) ? VALUE_WIDTH : 16;
  localparam logic [VALUE_WIDTH-1:0] Cap = '1;

  logic                   stage_q;
  logic [7:0]             byte_q;

  logic                   in_frame_q, in_frame_d;
  logic [4:0]             token_number_q, token_number_d;
  logic [3:0]             char_position_q, char_position_d;
  logic                   token_matches_q, token_matches_d;
  logic                   token_open_q, token_open_d;
  logic                   hex_stopped_q, hex_stopped_d;
  logic                   second_is_r_q, second_is_r_d;
  logic [AccW-1:0]        acc_q, acc_d;
  logic [VALUE_WIDTH-1:0] declared_q, declared_d;
  logic [VALUE_WIDTH-1:0] points_done_q, points_done_d;
  status_e                fault_q, fault_d;

  logic [VALUE_WIDTH-1:0] tok_val;
  logic                   tok_in_range;
  logic [4:0]             hx;
  logic [SumW-1:0]        sum;
  res_t                   point_res, status_res;
  push_t                  push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= 1'b0;
    end else begin
      stage_q <= byte_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_valid_i) begin
      byte_q <= byte_i;
    end
  end

  // accumulator holds cap+1 once it saturated
  assign tok_val      = acc_q[AccW-1] ? Cap : acc_q[VALUE_WIDTH-1:0];
  assign tok_in_range = CmpW'(tok_val) <= CmpW'(max_range_i);
  assign hx           = hex_digit(byte_q);

  always_comb begin
    in_frame_d      = in_frame_q;
    token_number_d  = token_number_q;
    char_position_d = char_position_q;
    token_matches_d = token_matches_q;
    token_open_d    = token_open_q;
    hex_stopped_d   = hex_stopped_q;
    second_is_r_d   = second_is_r_q;
    acc_d           = acc_q;
    declared_d      = declared_q;
    points_done_d   = points_done_q;
    fault_d         = fault_q;
    push            = '0;
    sum             = '0;

    point_res             = '0;
    point_res.kind        = KIND_POINT;
    point_res.point_index = 16'(points_done_q);
    point_res.distance_mm = 16'(tok_val);
    point_res.in_range    = tok_in_range;
    point_res.status      = ST_OK;
    status_res            = '0;

    if (stage_q) begin
      if (byte_q == ByteStx) begin
        in_frame_d      = 1'b1;
        token_number_d  = '0;
        char_position_d = '0;
        token_matches_d = 1'b1;
        token_open_d    = 1'b0;
        hex_stopped_d   = 1'b0;
        second_is_r_d   = 1'b0;
        acc_d           = '0;
        declared_d      = '0;
        points_done_d   = '0;
        fault_d         = ST_OK;
      end else if (in_frame_q) begin
        if (byte_q == ByteEtx || byte_q == ByteSep) begin
          if (token_open_q) begin
            token_open_d = 1'b0;
            if (declared_q != '0) begin
              push.res0     = point_res;
              push.num      = 2'd1;
              points_done_d = points_done_q + 1'b1;
            end else begin
              case (token_number_q)
                TokCommand: begin
                  if (!token_matches_q || char_position_q < CommandMinLen) fault_d = ST_BAD_TYPE;
                end
                TokName: begin
                  if (!token_matches_q || char_position_q != NameLen) fault_d = ST_BAD_NAME;
                end
                TokChannel: begin
                  if (!token_matches_q || char_position_q != ChannelLen) fault_d = ST_NOT_DIST;
                end
                TokCount: begin
                  declared_d = tok_val;
                end
                default: begin
                end
              endcase
            end
          end
          if (byte_q == ByteEtx) begin
            in_frame_d             = 1'b0;
            status_res.kind        = KIND_STATUS;
            status_res.point_total = 16'(declared_d);
            if (fault_d != ST_OK) status_res.status = fault_d;
            else if (points_done_d < declared_d) status_res.status = ST_SHORT_SCAN;
            else status_res.status = ST_OK;
            if (push.num == 2'd1) begin
              push.res1 = status_res;
              push.num  = 2'd2;
            end else begin
              push.res0 = status_res;
              push.num  = 2'd1;
            end
          end
          if (push.num == 2'd2) push.res1.last = 1'b1;
          else if (push.num == 2'd1) push.res0.last = 1'b1;
        end else begin
          // token character; first open a token if none is open
          if (!token_open_q) begin
            if (fault_q == ST_OK && !(declared_q != '0 && points_done_q >= declared_q)) begin
              token_open_d    = 1'b1;
              char_position_d = '0;
              token_matches_d = 1'b1;
              hex_stopped_d   = 1'b0;
              acc_d           = '0;
              if (declared_q == '0 && token_number_q != TokMax) begin
                token_number_d = token_number_q + 1'b1;
              end
            end
          end
          if (token_open_d) begin
            case (token_number_d)
              TokCommand: begin
                case (char_position_d)
                  4'd0: begin
                    if (byte_q != "s") token_matches_d = 1'b0;
                  end
                  4'd1: begin
                    if (byte_q == "R") second_is_r_d = 1'b1;
                    else if (byte_q == "S") second_is_r_d = 1'b0;
                    else token_matches_d = 1'b0;
                  end
                  4'd2: begin
                    if (byte_q != (second_is_r_q ? 8'("A") : 8'("N"))) token_matches_d = 1'b0;
                  end
                  default: begin
                  end
                endcase
              end
              TokName: begin
                if (char_position_d >= NameLen || byte_q != name_char(char_position_d)) begin
                  token_matches_d = 1'b0;
                end
              end
              TokChannel: begin
                if (char_position_d >= ChannelLen || byte_q != channel_char(char_position_d)) begin
                  token_matches_d = 1'b0;
                end
              end
              default: begin
              end
            endcase

            if (!hex_stopped_d) begin
              if (!hx[4]) begin
                hex_stopped_d = 1'b1;
              end else begin
                sum = {acc_d, 4'b0000} + SumW'(hx[3:0]);
                if (sum > SumW'(Cap)) acc_d = {1'b1, {VALUE_WIDTH{1'b0}}};
                else acc_d = AccW'(sum);
              end
            end
            if (char_position_d != CharPosMax) char_position_d = char_position_d + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q      <= 1'b0;
      token_number_q  <= '0;
      char_position_q <= '0;
      token_matches_q <= 1'b1;
      token_open_q    <= 1'b0;
      hex_stopped_q   <= 1'b0;
      second_is_r_q   <= 1'b0;
      acc_q           <= '0;
      declared_q      <= '0;
      points_done_q   <= '0;
      fault_q         <= ST_OK;
    end else begin
      in_frame_q      <= in_frame_d;
      token_number_q  <= token_number_d;
      char_position_q <= char_position_d;
      token_matches_q <= token_matches_d;
      token_open_q    <= token_open_d;
      hex_stopped_q   <= hex_stopped_d;
      second_is_r_q   <= second_is_r_d;
      acc_q           <= acc_d;
      declared_q      <= declared_d;
      points_done_q   <= points_done_d;
      fault_q         <= fault_d;
    end
  end

  assign busy_o = stage_q;
  assign push_o = push;

`ifndef SYNTHESIS
  a_two_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.num == 2'd2 |-> (push_o.res0.kind == KIND_POINT &&
                            push_o.res1.kind == KIND_STATUS && push_o.res1.last))
    else $error("two results must be a point followed by the closing status");

  a_point_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.num != 2'd0 && push_o.res0.kind == KIND_POINT) |-> points_done_q < declared_q)
    else $error("point given out beyond the declared count");

  a_fault_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_q != ST_OK |-> declared_q == '0)
    else $error("fault recorded after the point count was taken");
`endif

endmodule

>>> rtl/core/lstp_res_fifo.sv
// ----------------------------------------------------------------------------
// lstp_res_fifo
// Result queue: takes up to two results per cycle, hands out one per cycle when popped.
// ----------------------------------------------------------------------------
module lstp_res_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lstp_pkg::push_t               push_i,
  input  logic                          pop_i,
  output lstp_pkg::res_t                head_o,
  output logic                          head_valid_o,
  output logic [lstp_pkg::ResCntW-1:0]  count_o
);
  import lstp_pkg::*;

  res_t                 mem_q [ResFifoDepth];
  logic [ResPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [ResCntW-1:0]   count_q;
  logic [ResPtrW-1:0]   wr_ptr_nx;

  assign wr_ptr_nx = wr_ptr_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + ResPtrW'(push_i.num);
      if (pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q  <= count_q + ResCntW'(push_i.num) - ResCntW'(pop_i);
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign head_valid_o = count_q != '0;
  assign count_o      = count_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ResCntW'(ResFifoDepth))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(count_q) + 32'(push_i.num)) <= (32'(ResFifoDepth) + 32'(pop_i)))
    else $error("result queue overflow");

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 && push_i.num != 2'd0) |=> count_q != '0)
    else $error("pushed result lost");
`endif

endmodule

>>> rtl/core/lidar_ascii_scan_telegram_parser_core.sv
// ----------------------------------------------------------------------------
// lidar_ascii_scan_telegram_parser_core
// ASCII scan telegram parser: one byte per request in, points and status out.
// ----------------------------------------------------------------------------
// Path: a byte passes the input register, then is parsed into the result
//   queue, which hands the results out.
// Throughput: one byte per cycle while the result queue has room; a byte that
//   closes a data token at ETX gives two results, drained one per ready cycle.
// Reset: clears frame state and queue, max range returns to 10000 mm.
module lidar_ascii_scan_telegram_parser_core #(
  parameter int unsigned VALUE_WIDTH = lstp_pkg::ValueWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  lstp_stream_if.sink          in_i,
  lstp_stream_if.sink          cfg_i,
  lstp_stream_if.source        out_o
);
  import lstp_pkg::*;

  logic [15:0]          max_range_q;
  logic                 busy;
  push_t                push;
  res_t                 head;
  logic                 head_valid;
  logic                 pop;
  logic [ResCntW-1:0]   fifo_count;
  logic                 in_fire;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_range_q <= MaxRangeReset;
    end else if (cfg_i.valid) begin
      max_range_q <= cfg_i.data.max_range_mm;
    end
  end

  // room for two results from the byte in flight and two from the new one
  assign in_i.ready = busy ? (fifo_count <= ResCntW'(ResFifoDepth - 4))
                           : (fifo_count <= ResCntW'(ResFifoDepth - 2));
  assign in_fire    = in_i.valid && in_i.ready;

  lstp_parser #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_fire),
    .byte_i       (in_i.data.data_byte),
    .max_range_i  (max_range_q),
    .busy_o       (busy),
    .push_o       (push)
  );

  lstp_res_fifo u_res_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid),
    .count_o      (fifo_count)
  );

  assign pop         = head_valid && out_o.ready;
  assign out_o.valid = head_valid;
  assign out_o.data  = head;

endmodule

>>> verif/tb_lidar_ascii_scan_telegram_parser_core.sv
// ----------------------------------------------------------------------------
// tb_lidar_ascii_scan_telegram_parser_core
// Feeds byte streams of scan telegrams into the parser and checks every
// point and status request against an in-bench parser model. The stimulus
// mixes well-formed telegrams with random content, broken headers, short
// scans, restarts and line noise. It covers several max-range settings, and
// both ends idle and stall at random.
// ----------------------------------------------------------------------------
module tb_lidar_ascii_scan_telegram_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lstp_pkg::*;

  localparam int HoldLen = 300;
  localparam int PhaseBytes = 285;
  localparam logic [87:0] ScanName = "LMDscandata";
  localparam logic [39:0] DistName = "DIST1";

  logic clk_i = 1'b0;
  logic rst_ni;

  lstp_stream_if #(.T(in_t))  in_if ();
  lstp_stream_if #(.T(cfg_t)) cfg_if ();
  lstp_stream_if #(.T(res_t)) out_if ();

  lidar_ascii_scan_telegram_parser_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // byte stream waiting to be sent, and results the parser still owes
  logic [7:0] tx_bytes[$];
  res_t       due_results[$];

  // parser model state
  bit          fr_open;
  logic [4:0]  tok_no;
  logic [3:0]  chr_pos;
  bit          tok_ok;
  bit          tok_live;
  bit          hex_halt;
  bit          cmd_r;
  logic [16:0] hex_acc;
  logic [15:0] n_declared;
  logic [15:0] n_done;
  status_e     fault;
  logic [15:0] range_max;

  int   n_queued;
  int   n_frames;
  int   bytes_sent;
  int   mismatches;
  int   n_points;
  int   n_status;
  logic [4:0] status_seen;

  int   tx_gap;
  bit   tx_burst;
  int   rx_stall;
  bit   rx_burst;
  int   hold_cycles;
  bit   hold_on;
  bit   hold_done;

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic string fmt_res(input res_t r);
    return $sformatf("kind=%0d idx=%0d dist=%0d in_range=%0b status=%0d total=%0d last=%0b",
                     r.kind, r.point_index, r.distance_mm, r.in_range, r.status,
                     r.point_total, r.last);
  endfunction

  task automatic clear_scan();
    tok_no = '0;
    chr_pos = '0;
    tok_ok = 1'b1;
    tok_live = 1'b0;
    hex_halt = 1'b0;
    cmd_r = 1'b0;
    hex_acc = '0;
    n_declared = '0;
    n_done = '0;
    fault = ST_OK;
  endtask

  task automatic take_char(input logic [7:0] c);
    logic [20:0] t;
    int h;
    h = hex_nibble(c);
    if (tok_no == TokCommand) begin
      case (chr_pos)
        4'd0: if (c != "s") tok_ok = 1'b0;
        4'd1: begin
          if (c == "R") cmd_r = 1'b1;
          else if (c == "S") cmd_r = 1'b0;
          else tok_ok = 1'b0;
        end
        4'd2: if (c != (cmd_r ? "A" : "N")) tok_ok = 1'b0;
        default: ;
      endcase
    end else if (tok_no == TokName) begin
      if (chr_pos >= NameLen) tok_ok = 1'b0;
      else if (c != ScanName[87 - 8 * int'(chr_pos) -: 8]) tok_ok = 1'b0;
    end else if (tok_no == TokChannel) begin
      if (chr_pos >= ChannelLen) tok_ok = 1'b0;
      else if (c != DistName[39 - 8 * int'(chr_pos) -: 8]) tok_ok = 1'b0;
    end
    if (!hex_halt) begin
      if (h < 0) begin
        hex_halt = 1'b1;
      end else begin
        t = {hex_acc, 4'b0} + 21'(h);
        // one past the cap marks saturation
        hex_acc = (t > 21'hFFFF) ? 17'h10000 : t[16:0];
      end
    end
    if (chr_pos < CharPosMax) chr_pos++;
  endtask

  task automatic close_token(output bit got, output res_t pt);
    logic [15:0] v;
    v = (hex_acc > 17'hFFFF) ? 16'hFFFF : hex_acc[15:0];
    got = 1'b0;
    pt = '0;
    tok_live = 1'b0;
    if (n_declared != 0) begin
      pt.kind = KIND_POINT;
      pt.point_index = n_done;
      pt.distance_mm = v;
      pt.in_range = (v <= range_max);
      n_done++;
      got = 1'b1;
    end else if (tok_no == TokCommand) begin
      if (!tok_ok || chr_pos < CommandMinLen) fault = ST_BAD_TYPE;
    end else if (tok_no == TokName) begin
      if (!tok_ok || chr_pos != NameLen) fault = ST_BAD_NAME;
    end else if (tok_no == TokChannel) begin
      if (!tok_ok || chr_pos != ChannelLen) fault = ST_NOT_DIST;
    end else if (tok_no == TokCount) begin
      n_declared = v;
    end
  endtask

  // model of one accepted byte; owed results go to due_results
  task automatic parse_telegram_byte(input logic [7:0] c);
    res_t    made[$];
    res_t    pt;
    bit      got;
    status_e st;
    if (c == ByteStx) begin
      clear_scan();
      fr_open = 1'b1;
      return;
    end
    if (!fr_open) return;
    if (c == ByteEtx || c == ByteSep) begin
      if (tok_live) begin
        close_token(got, pt);
        if (got) made.push_back(pt);
      end
      if (c == ByteEtx) begin
        st = fault;
        if (st == ST_OK && n_done < n_declared) st = ST_SHORT_SCAN;
        pt = '0;
        pt.kind = KIND_STATUS;
        pt.status = st;
        pt.point_total = n_declared;
        made.push_back(pt);
        fr_open = 1'b0;
      end
      if (made.size() > 0) made[made.size() - 1].last = 1'b1;
      foreach (made[i]) due_results.push_back(made[i]);
      return;
    end
    if (!tok_live) begin
      if (fault != ST_OK) return;
      if (n_declared != 0 && n_done >= n_declared) return;
      tok_live = 1'b1;
      chr_pos = '0;
      tok_ok = 1'b1;
      hex_halt = 1'b0;
      hex_acc = '0;
      if (n_declared == 0 && tok_no < TokMax) tok_no++;
    end
    take_char(c);
  endtask

  // ---------------- byte stream building ----------------

  task automatic put(input logic [7:0] b);
    tx_bytes.push_back(b);
    n_queued++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  task automatic put_sep();
    put(ByteSep);
    if ($urandom_range(0, 6) == 0) put(ByteSep);
  endtask

  function automatic logic [7:0] rnd_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == ByteStx || b == ByteEtx || b == ByteSep);
    return b;
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] b;
    do b = rnd_char();
    while (hex_nibble(b) >= 0);
    return b;
  endfunction

  function automatic int hex_digits(input logic [31:0] v);
    int n;
    n = 1;
    while (n < 8 && (v >> (4 * n)) != 0) n++;
    return n;
  endfunction

  task automatic put_hex(input logic [31:0] v, input int ndig);
    logic [3:0] nib;
    for (int i = ndig - 1; i >= 0; i--) begin
      nib = (i < 8) ? v[4 * i +: 4] : 4'd0;
      if (nib < 10) put(8'("0") + 8'(nib));
      else put(($urandom_range(0, 1) ? 8'("A") : 8'("a")) + 8'(nib) - 8'd10);
    end
  endtask

  task automatic put_filler();
    repeat ($urandom_range(1, 2)) put(rnd_char());
  endtask

  task automatic put_point();
    int sel;
    logic [31:0] v;
    sel = $urandom_range(0, 19);
    v = $urandom_range(0, 65535) >> $urandom_range(0, 15);
    if (sel < 10) begin
      put_hex(v, hex_digits(v) + $urandom_range(0, 1));
    end else if (sel < 12) begin
      put_hex(32'(range_max), hex_digits(32'(range_max)));
    end else if (sel == 12) begin
      v = 32'(range_max) + 32'd1;
      put_hex(v, hex_digits(v));
    end else if (sel < 15) begin
      // long token: can saturate the value and the character position
      repeat ($urandom_range(5, 20)) put_hex($urandom_range(0, 15), 1);
    end else if (sel == 15) begin
      put(non_hex());
      put_hex(v, hex_digits(v));
    end else if (sel == 16) begin
      put_text("0x");
      put_hex(v, hex_digits(v));
    end else if (sel == 17) begin
      put_hex(v, hex_digits(v));
      put(non_hex());
      put_hex($urandom_range(0, 255), 2);
    end else begin
      put_hex((sel == 18) ? 32'd0 : 32'hFFFF, (sel == 18) ? 1 : 4);
    end
  endtask

  task automatic finish_early();
    put_sep();
    repeat ($urandom_range(0, 3)) begin
      put_filler();
      put_sep();
    end
    put(ByteEtx);
  endtask

  function automatic int pick_flavor();
    int r;
    r = $urandom_range(0, 19);
    if (r < 6) return 0;
    if (r < 9) return 1;
    if (r < 11) return r - 7;
    if (r < 13) return 4;
    return r - 8;
  endfunction

  // flavors: 0 clean, 1 last point runs into ETX, 2 zero count with long tail,
  // 3 saturated count, 4 short scan, 5 tokens after the points, 6 bad command,
  // 7 bad name, 8 bad channel, 9 ends before the count, 10 restart, 11 noise
  task automatic queue_scan(input int flavor);
    int n_decl;
    int n_pts;
    if (flavor == 11) begin
      repeat ($urandom_range(3, 8)) put(($urandom_range(0, 3) == 0) ? ByteEtx : rnd_char());
    end
    if (flavor == 10) begin
      put(ByteStx);
      repeat ($urandom_range(1, 6)) begin
        put_filler();
        put_sep();
      end
    end
    put(ByteStx);
    if ($urandom_range(0, 3) == 0) put(ByteSep);

    if (flavor == 6) begin
      case ($urandom_range(0, 5))
        0: put_text("sXA");
        1: put_text("sR");
        2: put_text("xRA");
        3: put_text("sRN");
        4: put_text("sSA");
        default: put_text("SRA");
      endcase
      finish_early();
      return;
    end
    case ($urandom_range(0, 3))
      0: put_text("sRA");
      1: put_text("sSN");
      2: put_text("sRAx");
      default: put_text("sSN1");
    endcase
    put_sep();

    if (flavor == 7) begin
      case ($urandom_range(0, 3))
        0: put_text("LMDscandat");
        1: put_text("LMDscandataX");
        2: put_text("LMDscanDATA");
        default: put_text("LMDscandataLMDscandata");
      endcase
      finish_early();
      return;
    end
    put_text("LMDscandata");
    put_sep();
    repeat (18) begin
      put_filler();
      put_sep();
    end

    if (flavor == 8) begin
      case ($urandom_range(0, 3))
        0: put_text("DIST2");
        1: put_text("DIST");
        2: put_text("DIST12");
        default: put_text("dist1");
      endcase
      finish_early();
      return;
    end
    put_text("DIST1");
    put_sep();
    if (flavor == 9) begin
      repeat ($urandom_range(0, 3)) begin
        put_filler();
        put_sep();
      end
      put(ByteEtx);
      return;
    end
    repeat (4) begin
      put_filler();
      put_sep();
    end

    if (flavor == 2) begin
      put_hex(0, $urandom_range(1, 3));
      put_sep();
      repeat ($urandom_range(6, 12)) begin
        put_filler();
        put_sep();
      end
      put(ByteEtx);
      return;
    end
    if (flavor == 3) begin
      case ($urandom_range(0, 2))
        0: put_text("FFFFF");
        1: put_text("10000");
        default: put_text("ffff");
      endcase
      n_pts = $urandom_range(1, 4);
    end else begin
      n_decl = $urandom_range(1, 16);
      put_hex(n_decl, hex_digits(n_decl) + $urandom_range(0, 2));
      n_pts = (flavor == 4) ? $urandom_range(0, n_decl - 1) : n_decl;
    end
    repeat (n_pts) begin
      put_sep();
      put_point();
    end
    if (flavor != 1) begin
      put_sep();
      if (flavor == 5) begin
        repeat ($urandom_range(1, 4)) begin
          put_point();
          put_sep();
        end
      end
    end
    put(ByteEtx);
  endtask

  // ---------------- sequencing ----------------

  task automatic settle();
    @(negedge clk_i);
    while (tx_bytes.size() != 0 || in_if.valid || due_results.size() != 0) @(negedge clk_i);
    // bytes that owe nothing may still be in the pipeline
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_range(input logic [15:0] v);
    @(posedge clk_i);
    cfg_if.data.max_range_mm <= v;
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_if.ready);
    range_max = v;
    cfg_if.valid <= 1'b0;
  endtask

  // byte driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data <= '0;
      tx_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        parse_telegram_byte(in_if.data.data_byte);
        bytes_sent <= bytes_sent + 1;
      end
      if (in_if.valid && !in_if.ready) begin
        // request held until taken
      end else if (tx_gap > 0 && !hold_on) begin
        tx_gap--;
        in_if.valid <= 1'b0;
      end else if (tx_bytes.size() != 0) begin
        in_if.data.data_byte <= tx_bytes.pop_front();
        in_if.valid <= 1'b1;
        if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
        tx_gap = tx_burst ? 0 : $urandom_range(0, 10);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    res_t want;
    res_t got;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (got.kind == KIND_POINT) n_points++;
        else begin
          n_status++;
          if (got.status <= ST_SHORT_SCAN) status_seen[got.status] = 1'b1;
        end
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: unexpected result %s", $time, fmt_res(got));
        end else begin
          want = due_results.pop_front();
          if (got.kind !== want.kind || got.point_index !== want.point_index ||
              got.distance_mm !== want.distance_mm || got.in_range !== want.in_range ||
              got.status !== want.status || got.point_total !== want.point_total ||
              got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch\n  expected %s\n  actual   %s", $time,
                       fmt_res(want), fmt_res(got));
            end
          end
        end
        if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
        rx_stall = rx_burst ? 0 : $urandom_range(0, 10);
      end
      if (hold_on) begin
        out_if.ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // one long receiver hold-off once traffic is flowing, so the result queue fills
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_on <= 1'b0;
    end else if (!hold_done && bytes_sent >= 500) begin
      if (hold_cycles < HoldLen) begin
        hold_on <= 1'b1;
        hold_cycles++;
      end else begin
        hold_on <= 1'b0;
        hold_done = 1'b1;
      end
    end
  end

  initial begin
    #3_000_000;
    $display("Timeout with %0d results still owed", due_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    range_max = MaxRangeReset;
    fr_open = 1'b0;
    status_seen = '0;
    clear_scan();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // noise outside a frame, empty frame, bad command, restart, short command
    put(8'h00);
    put(8'hFF);
    put(ByteEtx);
    put(8'h80);
    put(ByteStx);
    put(ByteEtx);
    put(ByteStx);
    put(ByteSep);
    put_text("sXA");
    put(ByteEtx);
    put(ByteStx);
    put("q");
    put(ByteStx);
    put(ByteEtx);
    put(ByteStx);
    put_text("sR");
    put(ByteEtx);

    for (int ph = 0; ph < 4; ph++) begin
      if (ph != 0) begin
        settle();
        case (ph)
          1: write_range(16'd0);
          2: write_range(16'hFFFF);
          default: write_range(16'($urandom_range(1, 65534)));
        endcase
      end
      @(negedge clk_i);
      while (n_queued < 20 + PhaseBytes * (ph + 1)) begin
        queue_scan((n_frames < 12) ? n_frames : pick_flavor());
        n_frames++;
      end
    end
    settle();

    $display("Sent %0d bytes in %0d telegrams over 4 max-range settings", bytes_sent, n_frames);
    $display("Checked %0d points and %0d status results, status codes seen %05b",
             n_points, n_status, status_seen);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
